// ===== rtl/dpf_pkg.sv =====
// dpf_pkg: shared types and constants for the duplicate-suppressing punch FIFO.
// No dependencies; imported by every module under rtl/.
`default_nettype none

package dpf_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam int OPCODE_W  = 2;
  localparam int STATUS_W  = 2;
  localparam int WORD_W    = 64;
  localparam int COUNT_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam int TYPE_IDX_W = 5;
  localparam int CODE_W    = 8;
  localparam int SENDER_W  = 32;

  localparam logic [TYPE_IDX_W-1:0] RST_TYPE_IDX   = 5'd0;
  localparam logic [CODE_W-1:0]     RST_STATION    = 8'd1;
  localparam logic [CODE_W-1:0]     RST_AIR_LAST   = 8'd2;
  localparam logic [CODE_W-1:0]     RST_AIR_MULTI  = 8'd3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2,
    OP_POP     = 2'd3
  } dpf_opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_DUP   = 2'd2,
    STAT_EMPTY = 2'd3
  } dpf_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TYPE_IDX  = 2'd0,
    CFG_STATION   = 2'd1,
    CFG_AIR_LAST  = 2'd2,
    CFG_AIR_MULTI = 2'd3
  } dpf_cfg_idx_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } dpf_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch input beat, issue head read
    logic execute;   // apply operation, load result register
  } dpf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // result register can take a new beat this cycle
    logic out_valid; // a result beat is pending
  } dpf_stat_t;

endpackage

`default_nettype wire

// ===== rtl/dpf_ctrl.sv =====
// dpf_ctrl: two-state sequencer (capture, execute) for the punch FIFO.
// Depends on dpf_pkg.
`default_nettype none

module dpf_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  dpf_pkg::dpf_stat_t stat,
  output dpf_pkg::dpf_cmd_t  cmd
);
  import dpf_pkg::*;

  dpf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.execute = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/dpf_datapath.sv =====
// dpf_datapath: record store, pointers, duplicate key, config registers and
// result register of the punch FIFO. Depends on dpf_pkg.
`default_nettype none

module dpf_datapath #(
  parameter int QUEUE_DEPTH = dpf_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  dpf_pkg::dpf_cmd_t               cmd,
  output dpf_pkg::dpf_stat_t              stat,
  input  wire [dpf_pkg::OPCODE_W-1:0]     in_opcode,
  input  wire [dpf_pkg::WORD_W-1:0]       in_payload_lo,
  input  wire [dpf_pkg::WORD_W-1:0]       in_payload_mid,
  input  wire [dpf_pkg::WORD_W-1:0]       in_payload_hi,
  input  wire                             cfg_we,
  input  wire [dpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [dpf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                             out_ready,
  output logic [dpf_pkg::STATUS_W-1:0]    out_status,
  output logic [dpf_pkg::WORD_W-1:0]      out_front_lo,
  output logic [dpf_pkg::WORD_W-1:0]      out_front_mid,
  output logic [dpf_pkg::WORD_W-1:0]      out_front_hi,
  output logic [dpf_pkg::COUNT_W-1:0]     out_item_count,
  output logic                            out_punches_exist
);
  import dpf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int REC_W = 3 * WORD_W;

  // config registers
  logic [TYPE_IDX_W-1:0] type_idx_r;
  logic [CODE_W-1:0]     station_r, air_last_r, air_multi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_idx_r  <= RST_TYPE_IDX;
      station_r   <= RST_STATION;
      air_last_r  <= RST_AIR_LAST;
      air_multi_r <= RST_AIR_MULTI;
    end else if (cfg_we) begin
      unique case (dpf_cfg_idx_t'(cfg_index))
        CFG_TYPE_IDX:  type_idx_r  <= cfg_data[TYPE_IDX_W-1:0];
        CFG_STATION:   station_r   <= cfg_data;
        CFG_AIR_LAST:  air_last_r  <= cfg_data;
        CFG_AIR_MULTI: air_multi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured input beat
  dpf_opcode_t        op_r;
  logic [WORD_W-1:0]  pl_lo_r, pl_mid_r, pl_hi_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= dpf_opcode_t'(in_opcode);
      pl_lo_r  <= in_payload_lo;
      pl_mid_r <= in_payload_mid;
      pl_hi_r  <= in_payload_hi;
    end
  end

  // queue control state
  logic [PTR_W-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic [OCC_W-1:0]    occ_r, occ_nxt;
  logic [SENDER_W-1:0] last_sid_r, last_sid_nxt;
  logic [CODE_W-1:0]   last_seq_r, last_seq_nxt;

  // record store, registered read at head
  logic [REC_W-1:0] mem [QUEUE_DEPTH];
  logic [REC_W-1:0] rd_data_r;
  logic             wr_en;

  always_ff @(posedge clk) begin
    if (cmd.capture) rd_data_r <= mem[head_r];
    if (wr_en) mem[tail_r] <= {pl_hi_r, pl_mid_r, pl_lo_r};
  end

  // key extraction
  logic [CODE_W-1:0]   type_code;
  logic [SENDER_W-1:0] sid;
  logic [CODE_W-1:0]   seq;

  always_comb begin
    type_code = '0;
    case (type_idx_r[4:3])
      2'd0: type_code = pl_lo_r[type_idx_r[2:0]*8 +: 8];
      2'd1: type_code = pl_mid_r[type_idx_r[2:0]*8 +: 8];
      2'd2: type_code = pl_hi_r[type_idx_r[2:0]*8 +: 8];
      default: type_code = '0;  // byte index past the record
    endcase
  end

  always_comb begin
    if (type_code == station_r) begin
      // big-endian bytes 4..7
      sid = {pl_lo_r[39:32], pl_lo_r[47:40], pl_lo_r[55:48], pl_lo_r[63:56]};
    end else if (type_code == air_last_r || type_code == air_multi_r) begin
      // big-endian bytes 15..18
      sid = {pl_mid_r[63:56], pl_hi_r[7:0], pl_hi_r[15:8], pl_hi_r[23:16]};
    end else begin
      sid = '0;
    end
    seq = pl_mid_r[31:24];
  end

  // operation
  logic        full, empty;
  dpf_status_t status;
  logic        rd_front;
  logic [PTR_W-1:0] head_inc, tail_inc;

  assign full     = (occ_r == OCC_W'(QUEUE_DEPTH));
  assign empty    = (occ_r == '0);
  assign head_inc = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
  assign tail_inc = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);

  always_comb begin
    status       = STAT_OK;
    rd_front     = 1'b0;
    wr_en        = 1'b0;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    occ_nxt      = occ_r;
    last_sid_nxt = last_sid_r;
    last_seq_nxt = last_seq_r;
    unique case (op_r)
      OP_ENQUEUE: begin
        if (full) begin
          status = STAT_FULL;
        end else if (sid == last_sid_r && seq == last_seq_r) begin
          status = STAT_DUP;
        end else begin
          wr_en        = cmd.execute;
          tail_nxt     = tail_inc;
          occ_nxt      = occ_r + OCC_W'(1);
          last_sid_nxt = sid;
          last_seq_nxt = seq;
        end
      end
      OP_DEQUEUE, OP_POP: begin
        if (empty) begin
          status = STAT_EMPTY;
        end else begin
          rd_front = (op_r == OP_DEQUEUE);
          head_nxt = head_inc;
          occ_nxt  = occ_r - OCC_W'(1);
        end
      end
      OP_PEEK: begin
        if (empty) status = STAT_EMPTY;
        else rd_front = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      occ_r      <= '0;
      last_sid_r <= '0;
      last_seq_r <= '0;
    end else if (cmd.execute) begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      occ_r      <= occ_nxt;
      last_sid_r <= last_sid_nxt;
      last_seq_r <= last_seq_nxt;
    end
  end

  // result register
  logic out_valid_r;

  assign stat.out_valid = out_valid_r;
  assign stat.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.execute) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_status        <= status;
      out_front_lo      <= rd_front ? rd_data_r[WORD_W-1:0]          : '0;
      out_front_mid     <= rd_front ? rd_data_r[2*WORD_W-1:WORD_W]   : '0;
      out_front_hi      <= rd_front ? rd_data_r[REC_W-1:2*WORD_W]    : '0;
      out_item_count    <= COUNT_W'(occ_nxt);
      out_punches_exist <= (occ_nxt != '0);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dedup_punch_fifo_top.sv =====
// dedup_punch_fifo_top: top level of the duplicate-suppressing punch FIFO.
// Instantiates dpf_ctrl and dpf_datapath; depends on dpf_pkg.
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------------------------------
//   in      | in_valid / in_ready    | in_opcode, in_payload_lo/mid/hi
//   out     | out_valid / out_ready  | out_status, out_front_lo/mid/hi,
//           |                        | out_item_count, out_punches_exist
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data (cfg_ready always high)
//
// Each beat is first captured, which also reads the head slot of the single-port
// record store, and then executed, which applies the operation and loads the result register.
// A finished result sits in its register while the next input beat is captured;
// the execute cycle stalls only while that register is still full.
// Synchronous active-low reset clears pointers, count, last key, config and valids.
// The record store has no reset; a slot's data is only returned after it was written.
`default_nettype none

module dedup_punch_fifo_top #(
  parameter int QUEUE_DEPTH = dpf_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire [dpf_pkg::OPCODE_W-1:0]     in_opcode,
  input  wire [dpf_pkg::WORD_W-1:0]       in_payload_lo,
  input  wire [dpf_pkg::WORD_W-1:0]       in_payload_mid,
  input  wire [dpf_pkg::WORD_W-1:0]       in_payload_hi,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [dpf_pkg::STATUS_W-1:0]    out_status,
  output logic [dpf_pkg::WORD_W-1:0]      out_front_lo,
  output logic [dpf_pkg::WORD_W-1:0]      out_front_mid,
  output logic [dpf_pkg::WORD_W-1:0]      out_front_hi,
  output logic [dpf_pkg::COUNT_W-1:0]     out_item_count,
  output logic                            out_punches_exist,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [dpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [dpf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dpf_pkg::*;

  dpf_cmd_t  cmd;
  dpf_stat_t stat;

  assign cfg_ready = 1'b1;
  assign out_valid = stat.out_valid;

  dpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dpf_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_opcode         (in_opcode),
    .in_payload_lo     (in_payload_lo),
    .in_payload_mid    (in_payload_mid),
    .in_payload_hi     (in_payload_hi),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_front_lo      (out_front_lo),
    .out_front_mid     (out_front_mid),
    .out_front_hi      (out_front_hi),
    .out_item_count    (out_item_count),
    .out_punches_exist (out_punches_exist)
  );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for dedup_punch_fifo_top (duplicate-dropping punch FIFO).
// Needs dpf_pkg and the RTL under rtl/; holds its own model of queue, key and registers.

module testbench;
  import dpf_pkg::*;

  localparam int DEPTH = DEFAULT_QUEUE_DEPTH;

  typedef struct {
    dpf_opcode_t  op;
    logic [191:0] pl;
  } punch_item_t;

  typedef struct {
    dpf_status_t   status;
    logic [191:0]  front;
    logic [COUNT_W-1:0] count;
    logic          exist;
  } punch_result_t;

  typedef struct {
    dpf_cfg_idx_t            idx;
    logic [CFG_DATA_W-1:0]   data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OPCODE_W-1:0] in_opcode = '0;
  logic [WORD_W-1:0] in_payload_lo = '0;
  logic [WORD_W-1:0] in_payload_mid = '0;
  logic [WORD_W-1:0] in_payload_hi = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [WORD_W-1:0] out_front_lo;
  logic [WORD_W-1:0] out_front_mid;
  logic [WORD_W-1:0] out_front_hi;
  logic [COUNT_W-1:0] out_item_count;
  logic out_punches_exist;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  dedup_punch_fifo_top #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_payload_lo(in_payload_lo), .in_payload_mid(in_payload_mid),
    .in_payload_hi(in_payload_hi),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_front_lo(out_front_lo), .out_front_mid(out_front_mid),
    .out_front_hi(out_front_hi), .out_item_count(out_item_count),
    .out_punches_exist(out_punches_exist),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // model of the block
  logic [191:0] record_store [DEPTH];
  int unsigned head_slot = 0;
  int unsigned tail_slot = 0;
  int unsigned held = 0;
  logic [31:0] last_sender = '0;
  logic [7:0]  last_seq = '0;
  logic [TYPE_IDX_W-1:0] type_idx_reg = RST_TYPE_IDX;
  logic [CODE_W-1:0] station_reg = RST_STATION;
  logic [CODE_W-1:0] air_last_reg = RST_AIR_LAST;
  logic [CODE_W-1:0] air_multi_reg = RST_AIR_MULTI;

  punch_item_t   pending_ops[$];
  punch_result_t expected_results[$];
  reg_write_t    pending_writes[$];
  punch_item_t   cur_item;
  reg_write_t    cur_write;

  int items_inflight = 0;
  int writes_inflight = 0;
  int items_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int fail_count = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  bit no_idle = 1'b0;

  // stimulus bookkeeping
  logic [191:0] prev_pl = '0;
  int           prev_kind = 0;
  logic [31:0]  prev_sender = '0;
  logic [7:0]   seq_ctr = '0;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [191:0] rand192();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic apply_punch_op(input punch_item_t it);
    punch_result_t r;
    logic [7:0] code;
    logic [31:0] sid;
    logic [7:0] seq;
    r.status = STAT_OK;
    r.front = '0;
    if (it.op == OP_ENQUEUE) begin
      if (held >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        code = (type_idx_reg < 24) ? it.pl[8*int'(type_idx_reg) +: 8] : 8'h00;
        // station match wins over an air code that shares its value
        if (code == station_reg)
          sid = swap32(it.pl[63:32]);
        else if (code == air_last_reg || code == air_multi_reg)
          sid = swap32(it.pl[151:120]);
        else
          sid = '0;
        seq = it.pl[95:88];
        if (sid == last_sender && seq == last_seq) begin
          r.status = STAT_DUP;
        end else begin
          record_store[tail_slot] = it.pl;
          tail_slot = (tail_slot + 1) % DEPTH;
          held++;
          last_sender = sid;
          last_seq = seq;
        end
      end
    end else if (held == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      if (it.op == OP_DEQUEUE || it.op == OP_PEEK)
        r.front = record_store[head_slot];
      if (it.op == OP_DEQUEUE || it.op == OP_POP) begin
        head_slot = (head_slot + 1) % DEPTH;
        held--;
      end
    end
    r.count = held[COUNT_W-1:0];
    r.exist = (held != 0);
    expected_results.push_back(r);
  endtask

  // input beat driver; predicts each beat as it is accepted
  always @(posedge clk) begin
    punch_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        apply_punch_op(cur_item);
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 && (no_idle || $urandom_range(0, 99) >= 29)) begin
          nxt = pending_ops.pop_front();
          cur_item = nxt;
          in_valid <= 1'b1;
          in_opcode <= nxt.op;
          in_payload_lo <= nxt.pl[63:0];
          in_payload_mid <= nxt.pl[127:64];
          in_payload_hi <= nxt.pl[191:128];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 29);
  end

  // register write driver
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cur_write.idx)
          CFG_TYPE_IDX:  type_idx_reg = cur_write.data[TYPE_IDX_W-1:0];
          CFG_STATION:   station_reg = cur_write.data;
          CFG_AIR_LAST:  air_last_reg = cur_write.data;
          CFG_AIR_MULTI: air_multi_reg = cur_write.data;
          default: ;
        endcase
        writes_inflight--;
      end
      if (!cfg_valid || cfg_ready) begin
        if (pending_writes.size() != 0) begin
          cur_write = pending_writes.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= cur_write.idx;
          cfg_data <= cur_write.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    punch_result_t want;
    bit bad;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("ERROR: result beat with nothing expected, status %0d", out_status);
        mismatch_count++;
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        items_inflight--;
        results_checked++;
        status_seen[int'(out_status)]++;
        bad = (out_status !== want.status) || (out_front_lo !== want.front[63:0]) ||
              (out_front_mid !== want.front[127:64]) ||
              (out_front_hi !== want.front[191:128]) ||
              (out_item_count !== want.count) || (out_punches_exist !== want.exist);
        if (bad) begin
          if (mismatch_count < 10) begin
            $display("ERROR: result %0d exp st=%0d cnt=%0d ex=%0d front=%h",
                     results_checked, want.status, want.count, want.exist, want.front);
            $display("       got st=%0d cnt=%0d ex=%0d front=%h", out_status,
                     out_item_count, out_punches_exist,
                     {out_front_hi, out_front_mid, out_front_lo});
          end
          mismatch_count++;
          fail_count++;
        end
      end
    end
  end

  task automatic queue_op(input dpf_opcode_t op, input logic [191:0] pl);
    punch_item_t it;
    it.op = op;
    it.pl = pl;
    pending_ops.push_back(it);
    items_inflight++;
    items_sent++;
  endtask

  // kind: 0 station, 1 first air, 2 second air, else random type code
  function automatic logic [191:0] make_punch(input int kind, input logic [31:0] sid,
                                              input logic [7:0] seq);
    logic [191:0] pl;
    logic [7:0] code;
    pl = rand192();
    case (kind)
      0: code = station_reg;
      1: code = air_last_reg;
      2: code = air_multi_reg;
      default: code = 8'($urandom);
    endcase
    if (kind == 0)
      pl[63:32] = swap32(sid);
    else
      pl[151:120] = swap32(sid);
    pl[95:88] = seq;
    if (type_idx_reg < 24)
      pl[8*int'(type_idx_reg) +: 8] = code;
    return pl;
  endfunction

  task automatic queue_fresh_punch();
    logic [31:0] sid;
    sid = ($urandom_range(0, 3) == 0) ? prev_sender : $urandom;
    prev_kind = $urandom_range(0, 3);
    prev_sender = sid;
    seq_ctr++;
    prev_pl = make_punch(prev_kind, sid, seq_ctr);
    queue_op(OP_ENQUEUE, prev_pl);
  endtask

  // same key again, either the identical record or new filler around the key
  task automatic queue_repeat_punch();
    if ($urandom_range(0, 1) != 0)
      queue_op(OP_ENQUEUE, prev_pl);
    else
      queue_op(OP_ENQUEUE, make_punch(prev_kind, prev_sender, seq_ctr));
  endtask

  function automatic dpf_opcode_t pick_read_op();
    case ($urandom_range(0, 2))
      0: return OP_DEQUEUE;
      1: return OP_PEEK;
      default: return OP_POP;
    endcase
  endfunction

  task automatic add_random(input int n);
    int stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if ($urandom_range(0, 1) != 0) queue_fresh_punch();
          else queue_op(pick_read_op(), rand192());
        end
        4, 5: begin
          // long enqueue run, enough to hit a full queue
          repeat ($urandom_range(14, 20)) begin
            if ($urandom_range(0, 7) == 0) queue_repeat_punch();
            else queue_fresh_punch();
          end
        end
        6: begin
          repeat ($urandom_range(10, 18)) queue_op(pick_read_op(), rand192());
        end
        7, 8: begin
          queue_fresh_punch();
          queue_repeat_punch();
        end
        default: queue_op(dpf_opcode_t'($urandom_range(0, 3)), rand192());
      endcase
    end
  endtask

  task automatic wait_drained();
    while (items_inflight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] idx, input logic [7:0] st,
                              input logic [7:0] al, input logic [7:0] am);
    reg_write_t w;
    w.idx = CFG_TYPE_IDX;  w.data = idx; pending_writes.push_back(w);
    w.idx = CFG_STATION;   w.data = st;  pending_writes.push_back(w);
    w.idx = CFG_AIR_LAST;  w.data = al;  pending_writes.push_back(w);
    w.idx = CFG_AIR_MULTI; w.data = am;  pending_writes.push_back(w);
    writes_inflight += 4;
    while (writes_inflight != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty reads, reset key, key across types, reads back
    queue_op(OP_DEQUEUE, rand192());
    queue_op(OP_PEEK, rand192());
    queue_op(OP_POP, rand192());
    queue_op(OP_ENQUEUE, '0);             // key 0/0 equals the reset key
    queue_op(OP_ENQUEUE, '1);             // unknown type, sequence 0xff
    prev_pl = make_punch(0, 32'h1234_5678, 8'h01);
    queue_op(OP_ENQUEUE, prev_pl);
    queue_op(OP_ENQUEUE, prev_pl);
    queue_op(OP_ENQUEUE, make_punch(0, 32'h1234_5678, 8'h02));
    queue_op(OP_ENQUEUE, make_punch(1, 32'h89ab_cdef, 8'h5a));
    queue_op(OP_ENQUEUE, make_punch(2, 32'h89ab_cdef, 8'h5a));
    queue_op(OP_ENQUEUE, make_punch(0, 32'h89ab_cdef, 8'h5a));
    queue_op(OP_PEEK, rand192());
    queue_op(OP_DEQUEUE, rand192());
    queue_op(OP_POP, rand192());
    queue_op(OP_PEEK, rand192());
    queue_op(OP_DEQUEUE, rand192());
    queue_op(OP_POP, rand192());
    queue_op(OP_DEQUEUE, '1);
    add_random(90);
    wait_drained();

    program_regs(8'd23, 8'hff, 8'h00, 8'h80);
    add_random(90);
    wait_drained();

    // type byte beyond the record reads as 0; station and first air code coincide
    no_idle = 1'b1;
    program_regs(8'd31, 8'h00, 8'h00, 8'h55);
    add_random(90);
    wait_drained();
    no_idle = 1'b0;

    // type byte overlaps the sequence byte
    program_regs(8'd11, 8'haa, 8'haa, 8'h0f);
    add_random(90);
    wait_drained();

    program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    add_random(90);
    wait_drained();
    repeat (8) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("ERROR: %0d expected results never arrived", expected_results.size());
      fail_count++;
    end
    $display("Covered %0d operations in five register settings, %0d results checked.",
             items_sent, results_checked);
    $display("Status counts: ok %0d, full %0d, duplicate %0d, empty %0d; mismatches %0d",
             status_seen[STAT_OK], status_seen[STAT_FULL], status_seen[STAT_DUP],
             status_seen[STAT_EMPTY], mismatch_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("ERROR: run did not finish in time");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
